// File: hw/rtl/lsm_pkg.sv
// constants and types shared by the line substring matcher
`timescale 1ns / 1ps

package lsm_pkg;

  localparam int PATTERN_BYTES_DEF    = 16;
  localparam int LINE_BYTES_DEF       = 256;
  localparam int LINE_NUMBER_BITS_DEF = 32;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int PATTERN_LEN_W     = 5;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 64;
  localparam int LINE_NUMBER_W     = 32;
  localparam int LINE_LENGTH_W     = 8;
  localparam int OUT_DATA_W        = LINE_NUMBER_W + LINE_LENGTH_W;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

endpackage

// File: hw/rtl/line_substring_matcher_unit.sv
// line splitter and fixed pattern matcher over a byte stream
`timescale 1ns / 1ps

// Takes one byte per cycle and groups the bytes into lines, a line ending at
// a newline or when LINE_BYTES-1 bytes are held. Each content byte enters a
// window of recent bytes that is compared in full against the configured
// pattern in the same cycle; a line that held a match gives one result with
// its line number (from 1) and its length including any newline. A transfer
// with tuser set closes a partial line and restarts the numbering. Every
// item goes through an input register, a compare and update step, and
// an output register, so one item is accepted every cycle while the result
// side takes its transfers. Configuration writes are meant for idle periods
// only.
module line_substring_matcher_unit #(
  parameter int PATTERN_BYTES    = lsm_pkg::PATTERN_BYTES_DEF,
  parameter int LINE_BYTES       = lsm_pkg::LINE_BYTES_DEF,
  parameter int LINE_NUMBER_BITS = lsm_pkg::LINE_NUMBER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [lsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,  // data_byte
  input  logic                           in_tuser,  // end_of_input
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lsm_pkg::OUT_DATA_W-1:0]  out_tdata  // line_length, line_number
);

  import lsm_pkg::*;

  localparam int WIN   = (PATTERN_BYTES < MAX_PATTERN_BYTES) ? PATTERN_BYTES
                                                             : MAX_PATTERN_BYTES;
  localparam int CNT_W = $clog2(LINE_BYTES);
  localparam int PIDX_W = $clog2(MAX_PATTERN_BYTES);

  // configuration registers
  logic [CFG_DATA_W-1:0]    pat_low_r;
  logic [CFG_DATA_W-1:0]    pat_high_r;
  logic [PATTERN_LEN_W-1:0] pat_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PATTERN_LOW:    pat_low_r  <= cfg_wdata;
        CFG_PATTERN_HIGH:   pat_high_r <= cfg_wdata;
        CFG_PATTERN_LENGTH: pat_len_r  <= cfg_wdata[PATTERN_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       s_valid_r;
  logic [7:0] s_byte_r;
  logic       s_eoi_r;
  logic       adv;
  logic       out_valid_r;

  assign adv       = s_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_byte_r <= in_tdata;
      s_eoi_r  <= in_tuser;
    end
  end

  // pattern alignment against the window, from the stable config registers
  logic [MAX_PATTERN_BYTES-1:0][7:0] pat_bytes;
  logic [PATTERN_LEN_W-1:0]          n_used;
  logic [WIN-1:0][7:0]               align;
  logic [WIN-1:0]                    in_use;

  assign pat_bytes = {pat_high_r, pat_low_r};
  assign n_used = (pat_len_r > PATTERN_LEN_W'(WIN)) ? PATTERN_LEN_W'(WIN) : pat_len_r;

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      in_use[i] = PATTERN_LEN_W'(i) < n_used;
      align[i]  = pat_bytes[PIDX_W'(n_used - PATTERN_LEN_W'(i) - PATTERN_LEN_W'(1))];
    end
  end

  // line state
  logic [WIN-1:0][7:0]          win_r, win_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt, cnt_inc;
  logic                         match_seen_r, match_seen_nxt;
  logic [LINE_NUMBER_BITS-1:0]  line_cnt_r, line_cnt_nxt, line_no_inc;
  logic                         is_content, all_eq, match_now, close, emit;
  logic [CNT_W-1:0]             close_len;

  always_comb begin
    cnt_inc    = cnt_r + CNT_W'(1);
    is_content = !s_eoi_r && (s_byte_r != NEWLINE_BYTE);
    win_nxt[0] = s_byte_r;
    for (int i = 1; i < WIN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    all_eq = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      if (in_use[i] && (win_nxt[i] != align[i])) begin
        all_eq = 1'b0;
      end
    end
    match_now   = is_content && ({{(32-CNT_W){1'b0}}, cnt_inc} >= 32'(n_used)) && all_eq;
    line_no_inc = line_cnt_r + LINE_NUMBER_BITS'(1);

    if (s_eoi_r) begin
      close     = cnt_r != '0;
      close_len = cnt_r;
    end else begin
      close     = !is_content || (cnt_inc >= CNT_W'(LINE_BYTES - 1));
      close_len = cnt_inc;
    end
    emit = close && (match_seen_r || match_now);

    win_nxt        = is_content ? win_nxt : win_r;
    cnt_nxt        = cnt_r;
    match_seen_nxt = match_seen_r;
    line_cnt_nxt   = line_cnt_r;
    if (s_eoi_r) begin
      cnt_nxt        = '0;
      match_seen_nxt = 1'b0;
      line_cnt_nxt   = '0;
    end else if (close) begin
      cnt_nxt        = '0;
      match_seen_nxt = 1'b0;
      line_cnt_nxt   = line_no_inc;
    end else begin
      cnt_nxt        = cnt_inc;
      match_seen_nxt = match_seen_r || match_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= '0;
      cnt_r        <= '0;
      match_seen_r <= 1'b0;
      line_cnt_r   <= '0;
    end else if (adv) begin
      win_r        <= win_nxt;
      cnt_r        <= cnt_nxt;
      match_seen_r <= match_seen_nxt;
      line_cnt_r   <= line_cnt_nxt;
    end
  end

  // output register
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_data_r <= {LINE_LENGTH_W'(close_len), LINE_NUMBER_W'(line_no_inc)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {{(32-CNT_W){1'b0}}, cnt_r} < 32'(LINE_BYTES - 1))
    else $error("line byte count reached the line limit");

  a_match_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    match_seen_r |-> (cnt_r != '0))
    else $error("match flagged on an empty line");

  a_eoi_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s_eoi_r) |=> (line_cnt_r == '0) && (cnt_r == '0))
    else $error("numbering not restarted after end of input");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !adv)
    else $error("pending result overwritten");

endmodule

// File: test/lsm_match_monitor.sv
// line matcher checker: predicts matching lines from the input transfers and compares results
`timescale 1ns / 1ps

module lsm_match_monitor
  import lsm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_DATA_W-1:0]  out_tdata,
  output int                     mismatches,
  output int                     outstanding,
  output int                     matches_checked
);

  typedef struct {
    logic [LINE_NUMBER_W-1:0] num;
    logic [LINE_LENGTH_W-1:0] len;
  } line_hit_t;

  logic [CFG_DATA_W-1:0]    pat_lo;
  logic [CFG_DATA_W-1:0]    pat_hi;
  logic [PATTERN_LEN_W-1:0] pat_len;
  logic [7:0]               window [MAX_PATTERN_BYTES];
  int unsigned              line_bytes;
  bit                       line_hit;
  logic [LINE_NUMBER_W-1:0] line_no;
  line_hit_t                hit_q [$];
  int                       fail_cnt;
  int                       done_cnt;

  function automatic logic [7:0] pattern_at(int j);
    if (j < 8) begin
      return pat_lo[8*j +: 8];
    end
    return pat_hi[8*(j-8) +: 8];
  endfunction

  task automatic close_line();
    line_no = line_no + 1'b1;
    if (line_hit) begin
      hit_q.push_back('{num: line_no, len: line_bytes[7:0]});
    end
    line_bytes = 0;
    line_hit   = 1'b0;
  endtask

  task automatic take_item(logic [7:0] d, logic eoi);
    int n;
    int k;
    bit same;
    if (eoi) begin
      if (line_bytes > 0) close_line();
      line_no = '0;
      return;
    end
    line_bytes++;
    if (d == NEWLINE_BYTE) begin
      close_line();
      return;
    end
    for (k = MAX_PATTERN_BYTES - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = d;
    n = (pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pat_len);
    if (line_bytes >= n && line_bytes != 0) begin
      same = 1'b1;
      for (k = 0; k < n; k++) begin
        if (window[n-1-k] != pattern_at(k)) same = 1'b0;
      end
      if (same) line_hit = 1'b1;
    end
    if (line_bytes >= LINE_BYTES_DEF - 1) close_line();
  endtask

  task automatic note_failure(string msg);
    if (fail_cnt < 10) $display("%0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    line_hit_t want;
    if (!rst_n) begin
      pat_lo     = '0;
      pat_hi     = '0;
      pat_len    = '0;
      line_bytes = 0;
      line_hit   = 1'b0;
      line_no    = '0;
      fail_cnt   = 0;
      done_cnt   = 0;
      foreach (window[i]) window[i] = 8'h00;
      hit_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (hit_q.size() == 0) begin
          note_failure($sformatf("result with nothing expected: line %0d length %0d",
                                 out_tdata[LINE_NUMBER_W-1:0],
                                 out_tdata[OUT_DATA_W-1:LINE_NUMBER_W]));
        end else begin
          want = hit_q.pop_front();
          done_cnt++;
          if (out_tdata[LINE_NUMBER_W-1:0] !== want.num ||
              out_tdata[OUT_DATA_W-1:LINE_NUMBER_W] !== want.len) begin
            note_failure($sformatf("mismatch: line exp %0d got %0d, length exp %0d got %0d",
                                   want.num, out_tdata[LINE_NUMBER_W-1:0], want.len,
                                   out_tdata[OUT_DATA_W-1:LINE_NUMBER_W]));
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PATTERN_LOW:    pat_lo  = cfg_wdata;
          CFG_PATTERN_HIGH:   pat_hi  = cfg_wdata;
          CFG_PATTERN_LENGTH: pat_len = cfg_wdata[PATTERN_LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_item(in_tdata, in_tuser);
    end
    mismatches      <= fail_cnt;
    outstanding     <= hit_q.size();
    matches_checked <= done_cnt;
  end

endmodule

// File: test/tb.sv
// top of the line matcher testbench: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;
  import lsm_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 56;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;

  int fails;
  int pending;
  int checked;
  int cycle_count = 0;
  int items_sent  = 0;
  int phases      = 0;
  int hold_req    = 0;
  int hold_done   = 0;
  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;

  logic [7:0] alpha [MAX_PATTERN_BYTES + 3];
  int         alpha_len;
  int         pat_used;

  line_substring_matcher_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lsm_match_monitor u_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatches      (fails),
    .outstanding     (pending),
    .matches_checked (checked)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side flow control
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req != hold_done) begin
        hold_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  task automatic put(logic [7:0] d, logic eoi, bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= eoi;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_pattern(logic [63:0] lo, logic [63:0] hi, logic [63:0] len_word);
    int j;
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_PATTERN_LOW;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CFG_PATTERN_HIGH;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_index <= CFG_PATTERN_LENGTH;
    cfg_wdata <= len_word;
    @(negedge clk);
    cfg_index <= CFG_SPARE_INDEX;
    cfg_wdata <= {$urandom, $urandom};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pat_used = (len_word[PATTERN_LEN_W-1:0] > MAX_PATTERN_BYTES) ?
               MAX_PATTERN_BYTES : int'(len_word[PATTERN_LEN_W-1:0]);
    for (j = 0; j < pat_used; j++) alpha[j] = (j < 8) ? lo[8*j +: 8] : hi[8*(j-8) +: 8];
    for (j = 0; j < 3; j++) alpha[pat_used + j] = 8'($urandom_range(0, 255));
    alpha_len = pat_used + 3;
    phases++;
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 9) < 8) return alpha[$urandom_range(0, alpha_len - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_line(int content_len, bit put_pattern);
    int pos;
    int k;
    int j;
    int cut;
    int r;
    bit gaps;
    pos  = put_pattern ? $urandom_range(0, content_len) : -1;
    cut  = ($urandom_range(0, 4) == 0 && pat_used > 0) ? 1 : 0;
    gaps = in_idle_on && ($urandom_range(0, 2) != 0);
    for (k = 0; k <= content_len; k++) begin
      if (k == pos) begin
        for (j = 0; j < pat_used - cut; j++) put(alpha[j], 1'b0, gaps);
      end
      if (k < content_len) put(pick_byte(), 1'b0, gaps);
    end
    r = $urandom_range(0, 19);
    if (r == 0) begin
      put(8'($urandom_range(0, 255)), 1'b1, gaps);
    end else if (r == 2) begin
      put(NEWLINE_BYTE, 1'b0, gaps);
      put(8'($urandom_range(0, 255)), 1'b1, gaps);
    end else if (r != 1) begin
      put(NEWLINE_BYTE, 1'b0, gaps);
    end
  endtask

  task automatic run_phase(logic [63:0] lo, logic [63:0] hi, logic [63:0] len_word,
                           bit long_first, bit pause_mid, bit hold);
    int start;
    bit paused;
    paused = 1'b0;
    wait_idle();
    program_pattern(lo, hi, len_word);
    if (hold) hold_req++;
    if (long_first) send_line(300, 1'b1);
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      if (pause_mid && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
      end
      if ($urandom_range(0, 49) == 0) begin
        send_line($urandom_range(240, 290), 1'($urandom_range(0, 1)));
      end else begin
        send_line($urandom_range(0, 20), $urandom_range(0, 4) < 3);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_PATTERN_LOW;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty pattern after reset: empty line, short lines, end marker with and without a line
    put(NEWLINE_BYTE, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(NEWLINE_BYTE, 1'b0, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(NEWLINE_BYTE, 1'b1, 1'b0);
    put(8'h00, 1'b1, 1'b0);

    // pattern ff 00 7a, must not match across a line boundary
    wait_idle();
    program_pattern(64'h0000_0000_007A_00FF, 64'h0, 64'd3);
    put(8'hFF, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(NEWLINE_BYTE, 1'b0, 1'b0);
    put(8'h7A, 1'b0, 1'b0);
    put(NEWLINE_BYTE, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'hFF, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'h7A, 1'b0, 1'b0);
    put(NEWLINE_BYTE, 1'b0, 1'b0);

    // pattern holding a newline never matches
    wait_idle();
    program_pattern(64'h0000_0000_0000_0A61, 64'h0, 64'd2);
    put(8'h61, 1'b0, 1'b0);
    put(NEWLINE_BYTE, 1'b0, 1'b0);
    put(8'h61, 1'b0, 1'b0);
    put(8'h61, 1'b1, 1'b0);

    run_phase(64'h0, 64'h0, 64'd0, 1'b0, 1'b0, 1'b1);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 64'd1, 1'b0, 1'b0, 1'b0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 64'd16, 1'b1, 1'b0, 1'b0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, 27'($urandom_range(0, 134217727)), 5'd31}, 1'b0, 1'b0, 1'b0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom_range(17, 30)),
              1'b0, 1'b0, 1'b0);
    run_phase(64'h0, {64{1'b1}}, 64'd12, 1'b0, 1'b0, 1'b0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom_range(2, 15)),
              1'b0, 1'b0, 1'b0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom_range(2, 8)),
              1'b0, 1'b1, 1'b0);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom_range(1, 6)),
              1'b0, 1'b0, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d bytes and end markers sent under %0d pattern settings", items_sent, phases);
    $display("%0d matching lines compared, incl. full lines and a %0d cycle result stall",
             checked, HOLD_CYCLES);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
